/* hdl/backward_rle_literal_unpacker_unit_assert.svh */
// Assertion macros for the backward run-length / literal unpacker.
// Included by the RTL modules that carry concurrent checks; needs nothing else.
`ifndef BACKWARD_RLE_LITERAL_UNPACKER_UNIT_ASSERT_SVH
`define BACKWARD_RLE_LITERAL_UNPACKER_UNIT_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is low.
`define BRLU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define BRLU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/brlu_pkg.sv */
// Shared types and constants for the backward run-length / literal unpacker.
// No dependencies.
package brlu_pkg;

    // Widths of the configuration register and internal counters
    localparam int unsigned CAP_W   = 20;
    localparam int unsigned COUNT_W = 16;

    // Reset value of the output capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 20'd1048560;

    // Byte codes of the packed stream
    localparam logic [7:0] PAD_BYTE = 8'hFF;
    localparam logic [7:0] OP_MASK  = 8'hFE;
    localparam logic [7:0] OP_FILL  = 8'hB0;
    localparam logic [7:0] OP_LIT   = 8'hB2;
    localparam logic [7:0] LAST_BIT = 8'h01;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_OP   = 2'd1,
        STATUS_NO_FILL  = 2'd2
    } t_status;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_PAD    = 3'd0,
        PH_CMD    = 3'd1,
        PH_HI     = 3'd2,
        PH_LO     = 3'd3,
        PH_FILL   = 3'd4,
        PH_LIT    = 3'd5,
        PH_HI_BAD = 3'd6,
        PH_LO_BAD = 3'd7
    } t_phase;

endpackage

/* hdl/backward_rle_literal_unpacker_unit.sv */
// Top level of the backward run-length / literal unpacker (single module).
// Depends on brlu_pkg and backward_rle_literal_unpacker_unit_assert.svh.
//
// Takes one packed byte per clock, from the end of the packed data toward its
// start, and gives at most one run word (value, repeat count, done, status) per
// byte. Each byte is decoded by the phase machine in the cycle it is accepted
// and its run word appears in the output register on the next cycle, so the
// sustained rate is one byte per cycle; the input stalls only while the output
// register holds a word that downstream has not taken. Leading 0xFF padding is
// skipped, a done word ends decoding and every byte after it is taken and
// dropped until reset. The capacity port is always ready and reloads the room
// counter; write it only while the block is idle.
`include "backward_rle_literal_unpacker_unit_assert.svh"

module backward_rle_literal_unpacker_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // capacity configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [brlu_pkg::CAP_W-1:0] i_cfg_output_capacity,
    // packed byte input
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_final_byte,
    // run word output
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_value,
    output logic [brlu_pkg::COUNT_W-1:0] o_repeat_res,
    output logic                       o_done_res,
    output logic [1:0]                 o_status
);
    import brlu_pkg::*;

    // Decoder state
    t_phase               r_phase,       n_phase;
    logic                 r_is_fill,     n_is_fill;
    logic                 r_last_block,  n_last_block;
    logic [7:0]           r_high_length, n_high_length;
    logic [COUNT_W-1:0]   r_run_count,   n_run_count;
    logic [CAP_W-1:0]     r_room_left,   n_room_left;
    logic [CAP_W-1:0]     r_capacity,    n_capacity;
    logic                 r_halted,      n_halted;

    // Output register
    logic                 r_out_valid,   n_out_valid;
    logic [7:0]           r_value,       n_value;
    logic [COUNT_W-1:0]   r_repeat,      n_repeat;
    logic                 r_done,        n_done;
    t_status              r_status,      n_status;

    logic                 in_accept;
    logic                 cfg_accept;

    // Advance the input while the output register is free or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid;

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_repeat_res = r_repeat;
    assign o_done_res   = r_done;
    assign o_status     = r_status;

    // Hold state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PAD;
            r_is_fill     <= 1'b0;
            r_last_block  <= 1'b0;
            r_high_length <= '0;
            r_run_count   <= '0;
            r_room_left   <= CAP_RESET;
            r_capacity    <= CAP_RESET;
            r_halted      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_is_fill     <= n_is_fill;
            r_last_block  <= n_last_block;
            r_high_length <= n_high_length;
            r_run_count   <= n_run_count;
            r_room_left   <= n_room_left;
            r_capacity    <= n_capacity;
            r_halted      <= n_halted;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_repeat <= n_repeat;
        r_done   <= n_done;
        r_status <= n_status;
    end

    // Decode one byte: next phase, counters and run word
    always_comb begin
        logic                 cmd_byte;
        logic                 res_valid;
        logic [7:0]           op;
        logic [COUNT_W-1:0]   lo_count;
        logic [COUNT_W-1:0]   fill_rep;
        logic [COUNT_W-1:0]   lit_run;
        logic [CAP_W-1:0]     lit_room;
        logic                 lit_end;

        n_phase       = r_phase;
        n_is_fill     = r_is_fill;
        n_last_block  = r_last_block;
        n_high_length = r_high_length;
        n_run_count   = r_run_count;
        n_room_left   = r_room_left;
        n_capacity    = r_capacity;
        n_halted      = r_halted;
        n_value       = r_value;
        n_repeat      = r_repeat;
        n_done        = r_done;
        n_status      = r_status;

        cmd_byte  = 1'b0;
        res_valid = 1'b0;
        op        = i_data_byte & OP_MASK;
        lo_count  = {r_high_length, i_data_byte};

        // Clip a fill run to the room left
        fill_rep  = ({{(CAP_W-COUNT_W){1'b0}}, r_run_count} < r_room_left)
                    ? r_run_count : r_room_left[COUNT_W-1:0];

        // Step a literal: count both down, saturating at zero
        lit_room  = (r_room_left != '0) ? r_room_left - 1'b1 : r_room_left;
        lit_run   = (r_run_count != '0) ? r_run_count - 1'b1 : r_run_count;
        lit_end   = (lit_run == '0) || (lit_room == '0) || i_final_byte;

        if (in_accept && !r_halted) begin
            unique case (r_phase)
                PH_PAD: begin
                    if (i_data_byte == PAD_BYTE) begin
                        if (i_final_byte) begin
                            res_valid = 1'b1;
                            n_value   = '0;
                            n_repeat  = '0;
                            n_done    = 1'b1;
                            n_status  = STATUS_OK;
                        end
                    end else begin
                        cmd_byte = 1'b1;
                    end
                end
                PH_CMD: begin
                    cmd_byte = 1'b1;
                end
                PH_HI, PH_HI_BAD: begin
                    if (i_final_byte) begin
                        res_valid = 1'b1;
                        n_value   = '0;
                        n_repeat  = '0;
                        n_done    = 1'b1;
                        n_status  = STATUS_OK;
                    end else begin
                        n_high_length = i_data_byte;
                        n_phase       = (r_phase == PH_HI) ? PH_LO : PH_LO_BAD;
                    end
                end
                PH_LO_BAD: begin
                    res_valid = 1'b1;
                    n_value   = '0;
                    n_repeat  = '0;
                    n_done    = 1'b1;
                    n_status  = STATUS_BAD_OP;
                end
                PH_LO: begin
                    n_run_count = lo_count;
                    if (r_is_fill) begin
                        if (i_final_byte) begin
                            res_valid = 1'b1;
                            n_value   = '0;
                            n_repeat  = '0;
                            n_done    = 1'b1;
                            n_status  = STATUS_NO_FILL;
                        end else begin
                            n_phase = PH_FILL;
                        end
                    end else if (lo_count == '0 || r_room_left == '0 || i_final_byte) begin
                        // empty literal, no room left or final byte: end the block now
                        if (r_last_block || i_final_byte) begin
                            res_valid = 1'b1;
                            n_value   = '0;
                            n_repeat  = '0;
                            n_done    = 1'b1;
                            n_status  = STATUS_OK;
                        end else begin
                            n_phase = PH_CMD;
                        end
                    end else begin
                        n_phase = PH_LIT;
                    end
                end
                PH_FILL: begin
                    n_room_left = r_room_left - {{(CAP_W-COUNT_W){1'b0}}, fill_rep};
                    n_phase     = PH_CMD;
                    res_valid   = 1'b1;
                    n_value     = i_data_byte;
                    n_repeat    = fill_rep;
                    n_done      = r_last_block || i_final_byte;
                    n_status    = STATUS_OK;
                end
                PH_LIT: begin
                    n_room_left = lit_room;
                    n_run_count = lit_run;
                    if (lit_end) begin
                        n_phase = PH_CMD;
                    end
                    res_valid = 1'b1;
                    n_value   = i_data_byte;
                    n_repeat  = COUNT_W'(1);
                    n_done    = lit_end && (r_last_block || i_final_byte);
                    n_status  = STATUS_OK;
                end
                default: begin
                end
            endcase

            // Decode a command byte
            if (cmd_byte) begin
                if (i_final_byte) begin
                    res_valid = 1'b1;
                    n_value   = '0;
                    n_repeat  = '0;
                    n_done    = 1'b1;
                    n_status  = STATUS_OK;
                end else begin
                    n_last_block = (i_data_byte & LAST_BIT) != '0;
                    n_is_fill    = (op == OP_FILL);
                    n_phase      = (op == OP_FILL || op == OP_LIT) ? PH_HI : PH_HI_BAD;
                end
            end
        end

        // Stop decoding after the done word
        if (res_valid && n_done) begin
            n_halted = 1'b1;
        end

        // Load the capacity and reload the room counter
        if (cfg_accept) begin
            n_capacity  = i_cfg_output_capacity;
            n_room_left = i_cfg_output_capacity;
        end

        // Fill or drain the output register
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Once halted and drained, no further word is produced
    `BRLU_ASSERT(a_halt_silent, i_clk, i_rst_n,
        (r_halted && !r_out_valid) |=> !r_out_valid, "word produced after done")

    // An error word is always a status-only done word
    `BRLU_ASSERT(a_error_done, i_clk, i_rst_n,
        (r_out_valid && r_status != STATUS_OK) |-> (r_done && r_repeat == '0 && r_value == '0),
        "error word without done or with payload")

    // Room never grows except by a capacity write
    `BRLU_ASSERT(a_room_monotonic, i_clk, i_rst_n,
        (!cfg_accept) |=> (r_room_left <= $past(r_room_left)), "room counter grew")

endmodule
